// ===== rtl/core/ndr_pkg.sv =====
`timescale 1ns / 1ps

package ndr_pkg;

    // Field widths
    localparam int BPC_W     = 22;
    localparam int CLU_W     = 63;
    localparam int CNT_W     = 48;
    localparam int RUN_CNT_W = 20;

    // Run limit: the run that brings the count to this value is refused
    localparam int MAX_RUNS = 1000000;

    // Command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BPC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAXC = 2'd1;

    localparam logic [BPC_W-1:0] BPC_RESET = 22'd4096;

    // Result event codes
    localparam logic [1:0] EV_RUN     = 2'd0;
    localparam logic [1:0] EV_RUN_END = 2'd1;
    localparam logic [1:0] EV_END     = 2'd2;
    localparam logic [1:0] EV_ERR     = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_BAD_HEADER = 3'd0;
    localparam logic [2:0] ERR_BEYOND_BUF = 3'd1;
    localparam logic [2:0] ERR_ZERO_LEN   = 3'd2;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
    localparam logic [2:0] ERR_NEGATIVE   = 3'd4;
    localparam logic [2:0] ERR_BEYOND_DSK = 3'd5;
    localparam logic [2:0] ERR_TOO_MANY   = 3'd6;

    // Command kinds passed from front to back
    typedef enum logic [1:0] {
        CMD_RUN,
        CMD_END,
        CMD_ERR
    } cmd_kind_t;

    // One classified command
    typedef struct packed {
        cmd_kind_t   kind;
        logic        clear;   // first command of a new list
        logic        last;    // buffer ended on this run
        logic        sparse;  // run without delta bytes
        logic [2:0]  code;    // error code for CMD_ERR
        logic [63:0] len;
        logic [63:0] delta;
    } cmd_t;

endpackage

// ===== rtl/core/ndr_if.sv =====
`timescale 1ns / 1ps

// Runlist byte stream
interface ndr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

// Decoded run / list events
interface ndr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [2:0]  error_code;
    logic [62:0] start_cluster;
    logic [47:0] cluster_count;
    logic [63:0] file_offset;
    logic [63:0] total_clusters;
    logic [63:0] total_bytes;

    modport source (output valid, event_res, error_code, start_cluster, cluster_count,
                    file_offset, total_clusters, total_bytes, input ready);
    modport sink   (input valid, event_res, error_code, start_cluster, cluster_count,
                    file_offset, total_clusters, total_bytes, output ready);
endinterface

// Configuration writes
interface ndr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ndr_pkg::CFG_IDX_W-1:0]  index;
    logic [63:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ntfs_data_run_decoder.sv =====
`timescale 1ns / 1ps

// NTFS runlist decoder. Takes one runlist byte per clock while the command
// queue has room (first_byte starts a new list) and returns at most one event
// per byte: a completed run with its start cluster, cluster count and file
// offset, a valid end of list with the totals, or an error that stops the
// list until the next first_byte. A front stage assembles header, length and
// delta fields and hands each finished run, end or error through a four-entry
// command queue to a three-stage back end (run checks and cluster bookkeeping,
// partial products of the cluster-size multiply, offset and total
// accumulation). An event passes through the queue and the stage 1, stage 2
// and output registers. The user must write bytes_per_cluster and max_cluster
// through cfg while no list is in flight; the block does not enforce it.

module ntfs_data_run_decoder (
    input  logic        clk,
    input  logic        rst_n,
    ndr_in_if.sink      runlist,
    ndr_out_if.source   result,
    ndr_cfg_if.sink     cfg
);

    logic [ndr_pkg::BPC_W-1:0] bpc_reg;
    logic [ndr_pkg::CLU_W-1:0] maxc_reg;

    logic          f_valid, f_ready;
    ndr_pkg::cmd_t f_cmd;
    logic          b_valid, b_ready;
    ndr_pkg::cmd_t b_cmd;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg  <= ndr_pkg::BPC_RESET;
            maxc_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                ndr_pkg::REG_BPC:  bpc_reg  <= cfg.data[ndr_pkg::BPC_W-1:0];
                ndr_pkg::REG_MAXC: maxc_reg <= cfg.data[ndr_pkg::CLU_W-1:0];
                default:           ;
            endcase
        end
    end

    ndr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .runlist   (runlist),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    ndr_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cmd),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (b_cmd)
    );

    ndr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd_ready (b_ready),
        .cmd       (b_cmd),
        .bpc       (bpc_reg),
        .maxc      (maxc_reg),
        .result    (result)
    );

endmodule

// ===== rtl/core/ndr_front.sv =====
`timescale 1ns / 1ps

module ndr_front (
    input  logic            clk,
    input  logic            rst_n,
    ndr_in_if.sink          runlist,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output ndr_pkg::cmd_t   cmd
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LENGTH,
        PH_DELTA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  len_cnt_reg, len_cnt_next;
    logic [3:0]  dlt_cnt_reg, dlt_cnt_next;
    logic [3:0]  dsize_reg, dsize_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] len_acc_reg, len_acc_next;
    logic [63:0] dlt_acc_reg, dlt_acc_next;
    logic        stopped_reg, stopped_next;
    logic        clr_pend_reg, clr_pend_next;

    logic        accept;
    logic        push;
    phase_t      ph;
    logic        stp;
    logic [7:0]  d;
    logic        last;
    logic [3:0]  lb;
    logic [3:0]  ob;
    logic [63:0] placed;
    logic [63:0] dlt_full;

    assign runlist.ready = cmd_ready;
    assign accept        = runlist.valid && runlist.ready;
    assign d             = runlist.data_byte;
    assign last          = runlist.last_byte;
    assign lb            = d[3:0];
    assign ob            = d[7:4];
    assign placed        = {56'b0, d} << {pos_reg, 3'b000};

    // Byte classification and field assembly
    always_comb
    begin
        phase_next    = phase_reg;
        len_cnt_next  = len_cnt_reg;
        dlt_cnt_next  = dlt_cnt_reg;
        dsize_next    = dsize_reg;
        pos_next      = pos_reg;
        len_acc_next  = len_acc_reg;
        dlt_acc_next  = dlt_acc_reg;
        stopped_next  = stopped_reg;
        clr_pend_next = clr_pend_reg;
        push          = 1'b0;
        dlt_full      = dlt_acc_reg | placed;

        cmd        = '0;
        cmd.kind   = ndr_pkg::CMD_RUN;
        cmd.len    = len_acc_reg;
        cmd.delta  = dlt_acc_reg;
        cmd.last   = last;

        ph  = runlist.first_byte ? PH_HEADER : phase_reg;
        stp = runlist.first_byte ? 1'b0 : stopped_reg;

        if (accept)
        begin
            if (runlist.first_byte)
            begin
                clr_pend_next = 1'b1;
                stopped_next  = 1'b0;
                phase_next    = PH_HEADER;
            end
            if (!stp)
            begin
                unique case (ph)
                    PH_HEADER:
                    begin
                        if (d == 8'd0)
                        begin
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_END;
                            stopped_next = 1'b1;
                        end
                        else if (lb == 4'd0 || lb > 4'd8 || ob > 4'd8)
                        begin
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_ERR;
                            cmd.code     = ndr_pkg::ERR_BAD_HEADER;
                            stopped_next = 1'b1;
                        end
                        else if (last)
                        begin
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_ERR;
                            cmd.code     = ndr_pkg::ERR_BEYOND_BUF;
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            len_cnt_next = lb;
                            dlt_cnt_next = ob;
                            dsize_next   = ob;
                            pos_next     = 3'd0;
                            len_acc_next = '0;
                            dlt_acc_next = '0;
                            phase_next   = PH_LENGTH;
                        end
                    end
                    PH_LENGTH:
                    begin
                        len_acc_next = len_acc_reg | placed;
                        pos_next     = pos_reg + 3'd1;
                        len_cnt_next = len_cnt_reg - 4'd1;
                        if (len_cnt_reg == 4'd1 && dlt_cnt_reg == 4'd0)
                        begin
                            // sparse run complete
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_RUN;
                            cmd.sparse   = 1'b1;
                            cmd.len      = len_acc_reg | placed;
                            cmd.delta    = '0;
                            phase_next   = PH_HEADER;
                            stopped_next = last;
                        end
                        else
                        begin
                            if (len_cnt_reg == 4'd1)
                            begin
                                phase_next = PH_DELTA;
                                pos_next   = 3'd0;
                            end
                            if (last)
                            begin
                                push         = 1'b1;
                                cmd.kind     = ndr_pkg::CMD_ERR;
                                cmd.code     = ndr_pkg::ERR_BEYOND_BUF;
                                stopped_next = 1'b1;
                                phase_next   = PH_HEADER;
                            end
                        end
                    end
                    PH_DELTA:
                    begin
                        dlt_acc_next = dlt_full;
                        pos_next     = pos_reg + 3'd1;
                        dlt_cnt_next = dlt_cnt_reg - 4'd1;
                        if (dlt_cnt_reg == 4'd1)
                        begin
                            // sign-extend a short delta
                            if (d[7] && dsize_reg < 4'd8)
                                dlt_full = dlt_full | ({64{1'b1}} << {dsize_reg, 3'b000});
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_RUN;
                            cmd.sparse   = 1'b0;
                            cmd.delta    = dlt_full;
                            phase_next   = PH_HEADER;
                            stopped_next = last;
                        end
                        else if (last)
                        begin
                            push         = 1'b1;
                            cmd.kind     = ndr_pkg::CMD_ERR;
                            cmd.code     = ndr_pkg::ERR_BEYOND_BUF;
                            stopped_next = 1'b1;
                            phase_next   = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HEADER;
                    end
                endcase
            end
            // tag the first command of a new list
            if (push)
            begin
                cmd.clear     = clr_pend_reg || runlist.first_byte;
                clr_pend_next = 1'b0;
            end
        end
    end

    assign cmd_valid = push;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            len_cnt_reg  <= '0;
            dlt_cnt_reg  <= '0;
            dsize_reg    <= '0;
            pos_reg      <= '0;
            len_acc_reg  <= '0;
            dlt_acc_reg  <= '0;
            stopped_reg  <= 1'b1;
            clr_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            len_cnt_reg  <= len_cnt_next;
            dlt_cnt_reg  <= dlt_cnt_next;
            dsize_reg    <= dsize_next;
            pos_reg      <= pos_next;
            len_acc_reg  <= len_acc_next;
            dlt_acc_reg  <= dlt_acc_next;
            stopped_reg  <= stopped_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

// ===== rtl/core/ndr_cmdq.sv =====
`timescale 1ns / 1ps

module ndr_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ndr_pkg::cmd_t   push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ndr_pkg::cmd_t   pop_data
);

    ndr_pkg::cmd_t              entry_reg [ndr_pkg::QDEPTH];
    logic [ndr_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [ndr_pkg::QPTR_W:0]   count_reg;
    logic                       do_push, do_pop;

    assign push_ready = (count_reg != (ndr_pkg::QPTR_W+1)'(ndr_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/ndr_back.sv =====
`timescale 1ns / 1ps

module ndr_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  ndr_pkg::cmd_t               cmd,
    input  logic [ndr_pkg::BPC_W-1:0]   bpc,
    input  logic [ndr_pkg::CLU_W-1:0]   maxc,
    ndr_out_if.source                   result
);

    // Running list state
    logic [62:0]                      cur_reg;
    logic [63:0]                      cs_reg;
    logic [ndr_pkg::RUN_CNT_W-1:0]    rc_reg;
    logic                             bstop_reg;
    logic [63:0]                      off_reg;

    // Stage 1: checks and cluster bookkeeping
    logic        s1_valid_reg, s1_emit_reg, s1_clear_reg, s1_adv_reg, s1_tb_reg;
    logic [1:0]  s1_ev_reg;
    logic [2:0]  s1_code_reg;
    logic [62:0] s1_start_reg;
    logic [47:0] s1_count_reg;
    logic [63:0] s1_tc_reg;

    // Stage 2: partial products
    logic        s2_valid_reg, s2_emit_reg, s2_clear_reg, s2_adv_reg, s2_tb_reg;
    logic [1:0]  s2_ev_reg;
    logic [2:0]  s2_code_reg;
    logic [62:0] s2_start_reg;
    logic [47:0] s2_count_reg;
    logic [63:0] s2_tc_reg;
    logic [45:0] s2_pl_reg, s2_ph_reg;
    logic [43:0] s2_q0_reg;
    logic [42:0] s2_q1_reg, s2_q2_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  out_ev_reg;
    logic [2:0]  out_code_reg;
    logic [62:0] out_start_reg;
    logic [47:0] out_count_reg;
    logic [63:0] out_off_reg, out_tc_reg, out_tb_reg;

    logic adv, take;

    // Stage 1 combinational
    logic [62:0]                   cur_base;
    logic [63:0]                   cs_base, cs_new, cur_new, end_sum;
    logic [ndr_pkg::RUN_CNT_W-1:0] rc_base;
    logic [ndr_pkg::RUN_CNT_W:0]   rc_inc;
    logic                          stop_eff;
    logic        s1_valid_next, s1_emit_next, s1_adv_next, s1_tb_next, stop_next;
    logic [1:0]  s1_ev_next;
    logic [2:0]  s1_code_next;
    logic [62:0] s1_start_next, cur_next;
    logic [63:0] s1_tc_next, cs_next;
    logic [ndr_pkg::RUN_CNT_W-1:0] rc_next;

    // Stage 3 combinational
    logic [63:0] off_inc, tb_full, off_base;

    assign adv       = !out_valid_reg || result.ready;
    assign cmd_ready = adv;
    assign take      = adv && cmd_valid;

    assign cur_base = cmd.clear ? '0 : cur_reg;
    assign cs_base  = cmd.clear ? '0 : cs_reg;
    assign rc_base  = cmd.clear ? '0 : rc_reg;
    assign stop_eff = cmd.clear ? 1'b0 : bstop_reg;
    assign cur_new  = {1'b0, cur_base} + cmd.delta;
    assign end_sum  = cur_new + cmd.len;
    assign cs_new   = cs_base + cmd.len;
    assign rc_inc   = {1'b0, rc_base} + 1'b1;

    // Run checks in list order
    always_comb
    begin
        s1_valid_next = !stop_eff;
        s1_emit_next  = 1'b0;
        s1_adv_next   = 1'b0;
        s1_tb_next    = 1'b0;
        s1_ev_next    = ndr_pkg::EV_ERR;
        s1_code_next  = ndr_pkg::ERR_BAD_HEADER;
        s1_start_next = '0;
        s1_tc_next    = '0;
        stop_next     = stop_eff;
        cur_next      = cur_base;
        cs_next       = cs_base;
        rc_next       = rc_base;

        if (!stop_eff)
        begin
            unique case (cmd.kind)
                ndr_pkg::CMD_END:
                begin
                    s1_emit_next = 1'b1;
                    s1_ev_next   = ndr_pkg::EV_END;
                    s1_tc_next   = cs_base;
                    s1_tb_next   = 1'b1;
                    stop_next    = 1'b1;
                end
                ndr_pkg::CMD_ERR:
                begin
                    s1_emit_next = 1'b1;
                    s1_code_next = cmd.code;
                    stop_next    = 1'b1;
                end
                ndr_pkg::CMD_RUN:
                begin
                    priority if (cmd.len == '0)
                    begin
                        s1_emit_next = 1'b1;
                        s1_code_next = ndr_pkg::ERR_ZERO_LEN;
                        stop_next    = 1'b1;
                    end
                    else if (cmd.len[63:ndr_pkg::CNT_W] != '0)
                    begin
                        s1_emit_next = 1'b1;
                        s1_code_next = ndr_pkg::ERR_TOO_LONG;
                        stop_next    = 1'b1;
                    end
                    else if (cmd.sparse)
                    begin
                        s1_adv_next = 1'b1;
                        if (cmd.last)
                        begin
                            s1_emit_next = 1'b1;
                            s1_ev_next   = ndr_pkg::EV_END;
                            s1_tc_next   = cs_base;
                            s1_tb_next   = 1'b1;
                            stop_next    = 1'b1;
                        end
                    end
                    else if (cur_new[63])
                    begin
                        s1_emit_next = 1'b1;
                        s1_code_next = ndr_pkg::ERR_NEGATIVE;
                        stop_next    = 1'b1;
                    end
                    else if (maxc != '0 && end_sum > {1'b0, maxc})
                    begin
                        s1_emit_next = 1'b1;
                        s1_code_next = ndr_pkg::ERR_BEYOND_DSK;
                        stop_next    = 1'b1;
                    end
                    else if (rc_inc >= (ndr_pkg::RUN_CNT_W+1)'(ndr_pkg::MAX_RUNS))
                    begin
                        s1_emit_next = 1'b1;
                        s1_code_next = ndr_pkg::ERR_TOO_MANY;
                        stop_next    = 1'b1;
                        cur_next     = cur_new[62:0];
                        cs_next      = cs_new;
                    end
                    else
                    begin
                        s1_emit_next  = 1'b1;
                        s1_adv_next   = 1'b1;
                        s1_ev_next    = cmd.last ? ndr_pkg::EV_RUN_END : ndr_pkg::EV_RUN;
                        s1_start_next = cur_new[62:0];
                        s1_tc_next    = cs_new;
                        s1_tb_next    = cmd.last;
                        s1_code_next  = ndr_pkg::ERR_BAD_HEADER;
                        stop_next     = cmd.last;
                        cur_next      = cur_new[62:0];
                        cs_next       = cs_new;
                        rc_next       = rc_inc[ndr_pkg::RUN_CNT_W-1:0];
                    end
                end
                default:
                begin
                    s1_valid_next = 1'b0;
                end
            endcase
        end
    end

    // Stage 3: combine partial products, running offset
    assign off_inc  = 64'(s2_pl_reg) + (64'(s2_ph_reg) << 24);
    assign tb_full  = 64'(s2_q0_reg) + (64'(s2_q1_reg) << 22) + (64'(s2_q2_reg) << 43);
    assign off_base = s2_clear_reg ? '0 : off_reg;

    // Control and list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            cs_reg        <= '0;
            rc_reg        <= '0;
            bstop_reg     <= 1'b1;
            off_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= take && s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg && s2_emit_reg;
            if (take)
            begin
                cur_reg   <= cur_next;
                cs_reg    <= cs_next;
                rc_reg    <= rc_next;
                bstop_reg <= stop_next;
            end
            if (s2_valid_reg)
                off_reg <= off_base + (s2_adv_reg ? off_inc : 64'd0);
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_emit_reg  <= s1_emit_next;
            s1_clear_reg <= cmd.clear;
            s1_adv_reg   <= s1_adv_next;
            s1_tb_reg    <= s1_tb_next;
            s1_ev_reg    <= s1_ev_next;
            s1_code_reg  <= s1_code_next;
            s1_start_reg <= s1_start_next;
            s1_count_reg <= cmd.len[ndr_pkg::CNT_W-1:0];
            s1_tc_reg    <= s1_tc_next;

            s2_emit_reg  <= s1_emit_reg;
            s2_clear_reg <= s1_clear_reg;
            s2_adv_reg   <= s1_adv_reg;
            s2_tb_reg    <= s1_tb_reg;
            s2_ev_reg    <= s1_ev_reg;
            s2_code_reg  <= s1_code_reg;
            s2_start_reg <= s1_start_reg;
            s2_count_reg <= s1_count_reg;
            s2_tc_reg    <= s1_tc_reg;
            s2_pl_reg    <= 46'(s1_count_reg[23:0]) * 46'(bpc);
            s2_ph_reg    <= 46'(s1_count_reg[47:24]) * 46'(bpc);
            s2_q0_reg    <= 44'(s1_tc_reg[21:0]) * 44'(bpc);
            s2_q1_reg    <= 43'(s1_tc_reg[42:22]) * 43'(bpc);
            s2_q2_reg    <= 43'(s1_tc_reg[63:43]) * 43'(bpc);

            out_ev_reg   <= s2_ev_reg;
            out_code_reg <= (s2_ev_reg == ndr_pkg::EV_ERR) ? s2_code_reg
                                                           : ndr_pkg::ERR_BAD_HEADER;
            if (s2_ev_reg == ndr_pkg::EV_RUN || s2_ev_reg == ndr_pkg::EV_RUN_END)
            begin
                out_start_reg <= s2_start_reg;
                out_count_reg <= s2_count_reg;
                out_off_reg   <= off_base;
            end
            else
            begin
                out_start_reg <= '0;
                out_count_reg <= '0;
                out_off_reg   <= '0;
            end
            out_tc_reg <= s2_tc_reg;
            out_tb_reg <= s2_tb_reg ? tb_full : 64'd0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.event_res      = out_ev_reg;
    assign result.error_code     = out_code_reg;
    assign result.start_cluster  = out_start_reg;
    assign result.cluster_count  = out_count_reg;
    assign result.file_offset    = out_off_reg;
    assign result.total_clusters = out_tc_reg;
    assign result.total_bytes    = out_tb_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] LEN_MAX  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] MASK63   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int          WD_LIMIT = 5000;
    localparam int          HOLD_LEN = 400;

    typedef enum logic [1:0] {AT_HEADER, IN_LENGTH, IN_DELTA} field_phase_t;
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {
        F_BAD_HEADER, F_EARLY_END, F_ZERO_LEN, F_TOO_LONG, F_NEGATIVE, F_BEYOND_DISK,
        F_RESTART
    } fault_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_first;
        logic       is_last;
    } runlist_byte_t;

    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  err;
        logic [62:0] start;
        logic [47:0] count;
        logic [63:0] offs;
        logic [63:0] total_cl;
        logic [63:0] total_by;
    } run_event_t;

    logic clk = 1'b0;
    logic rst_n;

    ndr_in_if  runlist_ch ();
    ndr_out_if result_ch ();
    ndr_cfg_if cfg_ch ();

    ntfs_data_run_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .runlist (runlist_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    always #4 clk = ~clk;

    // Stimulus and scoreboard storage
    runlist_byte_t pending_bytes[$];
    run_event_t    expected_events[$];
    int            bytes_queued = 0;
    int            bytes_sent   = 0;
    int            fail_cnt     = 0;
    idle_mode_t    idle_mode    = IDLE_NONE;
    bit            hold_req     = 1'b0;
    bit            hold_off     = 1'b0;
    logic          in_acc       = 1'b0;
    logic          out_acc      = 1'b0;
    logic          cfg_acc      = 1'b0;

    // Decoder mirror: configuration and list state
    logic [63:0]  cl_size;
    logic [63:0]  disk_clusters;
    field_phase_t phase;
    int           len_left, dlt_left, pos, dlt_size, runs;
    logic [63:0]  len_acc, dlt_acc, cur_clu, file_pos, clu_sum;
    logic         stopped;

    // Generator-side view of the list being built
    logic [63:0] gen_clu  = '0;
    logic [63:0] gen_maxc = '0;

    //------------------------------------------------------------------
    // Decoder mirror
    //------------------------------------------------------------------
    function automatic void restart_list();
        phase    = AT_HEADER;
        len_left = 0;
        dlt_left = 0;
        pos      = 0;
        dlt_size = 0;
        len_acc  = '0;
        dlt_acc  = '0;
        cur_clu  = '0;
        file_pos = '0;
        runs     = 0;
        clu_sum  = '0;
        stopped  = 1'b0;
    endfunction

    function automatic bit abort_list(input logic [2:0] code, output run_event_t r);
        r       = '0;
        r.ev    = ndr_pkg::EV_ERR;
        r.err   = code;
        stopped = 1'b1;
        phase   = AT_HEADER;
        return 1'b1;
    endfunction

    function automatic bit close_run(input logic is_last, output run_event_t r);
        logic [63:0] ln, nc, off;
        logic        sparse;
        ln     = len_acc;
        off    = file_pos;
        sparse = (dlt_size == 0);
        r      = '0;
        phase  = AT_HEADER;
        if (ln == 0)
            return abort_list(ndr_pkg::ERR_ZERO_LEN, r);
        if (ln > LEN_MAX)
            return abort_list(ndr_pkg::ERR_TOO_LONG, r);
        if (!sparse)
        begin
            nc = cur_clu + dlt_acc;
            if (nc[63])
                return abort_list(ndr_pkg::ERR_NEGATIVE, r);
            if (disk_clusters != 0 && nc + ln > disk_clusters)
                return abort_list(ndr_pkg::ERR_BEYOND_DSK, r);
            cur_clu = nc;
            clu_sum = clu_sum + ln;
            if (runs + 1 >= ndr_pkg::MAX_RUNS)
                return abort_list(ndr_pkg::ERR_TOO_MANY, r);
            runs++;
            r.start = nc[62:0];
        end
        file_pos = file_pos + ln * cl_size;
        if (is_last)
            stopped = 1'b1;
        if (!sparse)
        begin
            r.ev       = is_last ? ndr_pkg::EV_RUN_END : ndr_pkg::EV_RUN;
            r.count    = ln[47:0];
            r.offs     = off;
            r.total_cl = clu_sum;
            r.total_by = is_last ? clu_sum * cl_size : 64'd0;
            return 1'b1;
        end
        if (is_last)
        begin
            r.ev       = ndr_pkg::EV_END;
            r.total_cl = clu_sum;
            r.total_by = clu_sum * cl_size;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One runlist byte in, at most one event out
    function automatic bit decode_byte(input logic [7:0] d, input logic is_first,
                                       input logic is_last, output run_event_t r);
        r = '0;
        if (is_first)
            restart_list();
        if (stopped)
            return 1'b0;
        case (phase)
            AT_HEADER:
            begin
                if (d == 8'h00)
                begin
                    stopped    = 1'b1;
                    r.ev       = ndr_pkg::EV_END;
                    r.total_cl = clu_sum;
                    r.total_by = clu_sum * cl_size;
                    return 1'b1;
                end
                if (d[3:0] == 0 || d[3:0] > 8 || d[7:4] > 8)
                    return abort_list(ndr_pkg::ERR_BAD_HEADER, r);
                if (is_last)
                    return abort_list(ndr_pkg::ERR_BEYOND_BUF, r);
                len_left = int'(d[3:0]);
                dlt_left = int'(d[7:4]);
                dlt_size = int'(d[7:4]);
                pos      = 0;
                len_acc  = '0;
                dlt_acc  = '0;
                phase    = IN_LENGTH;
                return 1'b0;
            end
            IN_LENGTH:
            begin
                len_acc = len_acc | (64'(d) << (8 * (pos & 7)));
                pos++;
                if (len_left > 0)
                    len_left--;
                if (len_left == 0)
                begin
                    if (dlt_left == 0)
                        return close_run(is_last, r);
                    phase = IN_DELTA;
                    pos   = 0;
                end
                if (is_last)
                    return abort_list(ndr_pkg::ERR_BEYOND_BUF, r);
                return 1'b0;
            end
            default:
            begin
                dlt_acc = dlt_acc | (64'(d) << (8 * (pos & 7)));
                pos++;
                if (dlt_left > 0)
                    dlt_left--;
                if (dlt_left == 0)
                begin
                    // sign-extend a short delta
                    if (d[7] && dlt_size < 8)
                        dlt_acc = dlt_acc | (~64'd0 << (8 * dlt_size));
                    return close_run(is_last, r);
                end
                if (is_last)
                    return abort_list(ndr_pkg::ERR_BEYOND_BUF, r);
                return 1'b0;
            end
        endcase
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int width_unsigned(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 8 && (v >> (8 * n)) != 0)
            n++;
        return n;
    endfunction

    function automatic int width_signed(input logic [63:0] v);
        int n;
        n = 1;
        while (n < 8 && ($signed(v) >>> (8 * n - 1)) != 0 &&
               ($signed(v) >>> (8 * n - 1)) != -1)
            n++;
        return n;
    endfunction

    function automatic int pad_bytes();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    function automatic logic [63:0] pick_length();
        int sel;
        logic [63:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            v = 64'($urandom_range(1, 255));
        else if (sel < 8)
            v = 64'($urandom_range(1, 65535));
        else if (sel == 8)
            v = 64'($urandom_range(1, 24'hFF_FFFF));
        else
            v = rand64() & LEN_MAX;
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic logic [63:0] pick_target(input logic [63:0] ln);
        int sel;
        if (gen_maxc != 0)
            return rand64() % (gen_maxc - ln + 64'd1);
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            if (gen_clu > 1000 && $urandom_range(0, 2) == 0)
                return gen_clu - 64'($urandom_range(1, 1000));
            return gen_clu + 64'($urandom_range(0, 100000));
        end
        if (sel == 7)
            return rand64() >> 1;
        if (sel == 8)
            return 64'($urandom);
        return gen_clu;
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic is_first, input logic is_last);
        runlist_byte_t b;
        b.data     = d;
        b.is_first = is_first;
        b.is_last  = is_last;
        pending_bytes.insert(pending_bytes.size(), b);
        bytes_queued++;
    endtask

    // Header, little-endian length, little-endian delta; last mark at byte last_at
    task automatic add_run(input logic [63:0] ln, input int lb, input int ob,
                           input logic [63:0] dl, input logic is_first, input int last_at);
        int k;
        push_byte({4'(ob), 4'(lb)}, is_first, last_at == 0);
        for (k = 0; k < lb; k++)
            push_byte(ln[8 * k +: 8], 1'b0, last_at == 1 + k);
        for (k = 0; k < ob; k++)
            push_byte(dl[8 * k +: 8], 1'b0, last_at == 1 + lb + k);
    endtask

    // A runlist of nruns runs; a broken one carries at most one fault, at a random run
    task automatic queue_list(input int nruns, input bit broken);
        int          i, fault_at, lb, ob, nb, last_at, cut;
        logic [63:0] ln, tgt, dl;
        bit          sparse, end_by_last;
        fault_t      fk;
        gen_clu     = '0;
        fault_at    = broken ? $urandom_range(0, nruns - 1) : -1;
        fk          = fault_t'($urandom_range(0, int'(F_RESTART)));
        end_by_last = 1'($urandom_range(0, 1));
        for (i = 0; i < nruns; i++)
        begin
            ln     = pick_length();
            sparse = ($urandom_range(0, 4) == 0);
            if (gen_maxc != 0 && ln > gen_maxc)
                ln = 64'd1 + ln % gen_maxc;
            tgt     = sparse ? gen_clu : pick_target(ln);
            last_at = -1;
            if (i == fault_at)
            begin
                case (fk)
                    F_BAD_HEADER:
                    begin
                        case ($urandom_range(0, 2))
                            0: push_byte({4'($urandom_range(1, 15)), 4'h0}, i == 0,
                                         1'($urandom_range(0, 1)));
                            1: push_byte({4'($urandom_range(0, 15)), 4'($urandom_range(9, 15))},
                                         i == 0, 1'($urandom_range(0, 1)));
                            default: push_byte({4'($urandom_range(9, 15)),
                                                4'($urandom_range(0, 15))},
                                               i == 0, 1'($urandom_range(0, 1)));
                        endcase
                        continue;
                    end
                    F_ZERO_LEN: ln = 0;
                    F_TOO_LONG: ln = rand64() | (64'd1 << $urandom_range(48, 63));
                    F_NEGATIVE:
                    begin
                        sparse = 1'b0;
                        tgt = $urandom_range(0, 1) ? (64'h8000_0000_0000_0000 | rand64())
                                                   : (64'd0 - 64'($urandom_range(1, 100000)));
                    end
                    F_BEYOND_DISK:
                    begin
                        if (gen_maxc != 0 && gen_maxc < 64'h4000_0000_0000_0000)
                        begin
                            sparse = 1'b0;
                            tgt    = gen_maxc - ln + 64'd1 + 64'($urandom_range(0, 1000));
                        end
                    end
                    default: ;
                endcase
            end
            dl = tgt - gen_clu;
            lb = width_unsigned(ln) + pad_bytes();
            if (lb > 8)
                lb = 8;
            ob = 0;
            if (!sparse)
            begin
                ob = width_signed(dl) + pad_bytes();
                if (ob > 8)
                    ob = 8;
            end
            nb = 1 + lb + ob;
            if (i == nruns - 1 && end_by_last)
                last_at = nb - 1;
            if (i == fault_at && fk == F_EARLY_END)
                last_at = $urandom_range(0, nb - 2);
            if (i == fault_at && fk == F_RESTART)
            begin
                // partial run; the next list's first mark cuts it off
                cut = $urandom_range(0, lb - 1);
                push_byte({4'(ob), 4'(lb)}, i == 0, 1'b0);
                for (int k = 0; k < cut; k++)
                    push_byte(ln[8 * k +: 8], 1'b0, 1'b0);
                return;
            end
            add_run(ln, lb, ob, dl, i == 0, last_at);
            if (!sparse)
                gen_clu = tgt;
        end
        if (!end_by_last)
            push_byte(8'h00, 1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_random(input int n);
        int goal, sel, k;
        goal = bytes_queued + n;
        while (bytes_queued < goal)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                queue_list($urandom_range(1, 10), 1'b0);
            else if (sel < 9)
                queue_list($urandom_range(1, 8), 1'b1);
            else
                for (k = $urandom_range(3, 12); k > 0; k--)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic write_reg(input logic [ndr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(negedge clk);
        while (!cfg_acc)
            @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_idle();
        while (bytes_sent != bytes_queued || expected_events.size() != 0)
            @(negedge clk);
        repeat (16) @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        fail_cnt++;
    endtask

    function automatic bit sender_gap();
        return (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 54) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 6);
    endfunction

    function automatic bit receiver_stall();
        return (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 54) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 6);
    endfunction

    //------------------------------------------------------------------
    // Byte driver: a new transaction once the current one is taken
    //------------------------------------------------------------------
    always @(negedge clk)
    begin
        runlist_byte_t nxt;
        if (rst_n && (!runlist_ch.valid || in_acc))
        begin
            if (pending_bytes.size() != 0 && !sender_gap())
            begin
                nxt = pending_bytes.pop_front();
                runlist_ch.valid      <= 1'b1;
                runlist_ch.data_byte  <= nxt.data;
                runlist_ch.first_byte <= nxt.is_first;
                runlist_ch.last_byte  <= nxt.is_last;
            end
            else
                runlist_ch.valid <= 1'b0;
        end
    end

    // Result backpressure
    always @(negedge clk)
    begin
        result_ch.ready <= !hold_off && !receiver_stall();
    end

    // Long receiver hold-off so the command queue fills and the input stalls
    initial
    begin
        wait (hold_req);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_off = 1'b0;
    end

    //------------------------------------------------------------------
    // Monitor: check results, then predict from accepted bytes
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        run_event_t got, want, pred;
        in_acc  <= runlist_ch.valid && runlist_ch.ready;
        out_acc <= result_ch.valid && result_ch.ready;
        cfg_acc <= cfg_ch.valid && cfg_ch.ready;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.ev       = result_ch.event_res;
                got.err      = result_ch.error_code;
                got.start    = result_ch.start_cluster;
                got.count    = result_ch.cluster_count;
                got.offs     = result_ch.file_offset;
                got.total_cl = result_ch.total_clusters;
                got.total_by = result_ch.total_bytes;
                if (expected_events.size() == 0)
                    report_mismatch("unexpected event_res", 64'(got.ev), 64'd0);
                else
                begin
                    want = expected_events.pop_front();
                    if (got.ev !== want.ev)
                        report_mismatch("event_res", 64'(got.ev), 64'(want.ev));
                    if (got.err !== want.err)
                        report_mismatch("error_code", 64'(got.err), 64'(want.err));
                    if (got.start !== want.start)
                        report_mismatch("start_cluster", 64'(got.start), 64'(want.start));
                    if (got.count !== want.count)
                        report_mismatch("cluster_count", 64'(got.count), 64'(want.count));
                    if (got.offs !== want.offs)
                        report_mismatch("file_offset", got.offs, want.offs);
                    if (got.total_cl !== want.total_cl)
                        report_mismatch("total_clusters", got.total_cl, want.total_cl);
                    if (got.total_by !== want.total_by)
                        report_mismatch("total_bytes", got.total_by, want.total_by);
                end
            end
            if (runlist_ch.valid && runlist_ch.ready)
            begin
                bytes_sent++;
                if (decode_byte(runlist_ch.data_byte, runlist_ch.first_byte,
                                runlist_ch.last_byte, pred))
                    expected_events.insert(expected_events.size(), pred);
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    ndr_pkg::REG_BPC:
                        cl_size = {42'd0, cfg_ch.data[ndr_pkg::BPC_W-1:0]};
                    ndr_pkg::REG_MAXC:
                        disk_clusters = {1'b0, cfg_ch.data[ndr_pkg::CLU_W-1:0]};
                    default: ;
                endcase
            end
        end
    end

    // Watchdog: cycles without any transaction on any channel
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WD_LIMIT)
        begin
            @(negedge clk);
            if (in_acc || out_acc || cfg_acc)
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        int          p;
        logic [63:0] bpc_val, maxc_val;

        runlist_ch.valid      = 1'b0;
        runlist_ch.data_byte  = '0;
        runlist_ch.first_byte = 1'b0;
        runlist_ch.last_byte  = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = ndr_pkg::REG_BPC;
        cfg_ch.data           = '0;

        // mirror reset state: idle until a first mark
        cl_size       = {42'd0, ndr_pkg::BPC_RESET};
        disk_clusters = '0;
        restart_list();
        stopped = 1'b1;

        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Directed: stopped list, runs, sparse, errors, ends
        push_byte(8'h11, 1'b0, 1'b0);   // ignored before any first mark
        push_byte(8'h05, 1'b0, 1'b0);
        push_byte(8'h11, 1'b1, 1'b0);   // run: count 255, start 127
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);   // sparse run, offset only
        push_byte(8'h10, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b0);   // delta 0x80 drives cluster negative
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);   // ignored after the error
        push_byte(8'hF1, 1'b1, 1'b0);   // bad header
        push_byte(8'h01, 1'b1, 1'b1);   // buffer ends on a header
        push_byte(8'h01, 1'b1, 1'b0);   // zero length
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h01, 1'b1, 1'b0);   // sparse run ends the buffer
        push_byte(8'h05, 1'b0, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);   // run ends the buffer
        push_byte(8'h03, 1'b0, 1'b0);
        push_byte(8'h10, 1'b0, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);   // first mark in mid-run
        push_byte(8'h05, 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);
        queue_random(60);
        wait_idle();

        // Random phases over several register settings and idle patterns
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: begin bpc_val = 64'd1;         maxc_val = 64'd0;             end
                1: begin bpc_val = 64'd2097152;   maxc_val = MASK63;            end
                2: begin bpc_val = 64'h3F_FFFF;   maxc_val = 64'd1000;          end
                3: begin bpc_val = 64'd0;         maxc_val = 64'd0;             end
                4: begin bpc_val = 64'd4096;      maxc_val = rand64() >> 24;    end
                5:
                begin
                    bpc_val  = 64'($urandom_range(1, 2097152));
                    maxc_val = 64'd1;
                end
                6: begin bpc_val = 64'd512;       maxc_val = 64'd0;             end
                default:
                begin
                    bpc_val  = 64'($urandom_range(0, 22'h3FFFFF));
                    maxc_val = rand64() >> 1;
                end
            endcase
            write_reg(ndr_pkg::REG_BPC, bpc_val);
            write_reg(ndr_pkg::REG_MAXC, maxc_val);
            gen_maxc  = maxc_val;
            idle_mode = idle_mode_t'(p % 4);
            if (p == 4)
                hold_req = 1'b1;
            queue_random(115);
            wait_idle();
        end

        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
